/* design/ring_interpolation_coefficients_unit_defines.svh */
// assertion macros for the ring interpolation coefficients unit
`ifndef RING_INTERPOLATION_COEFFICIENTS_UNIT_DEFINES_SVH
`define RING_INTERPOLATION_COEFFICIENTS_UNIT_DEFINES_SVH

// condition holds in the same cycle
`define RIC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ric same-cycle check failed");

// condition holds in the next cycle
`define RIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ric next-cycle check failed");

`endif

/* design/ric_pkg.sv */
// shared codes for the ring interpolation coefficients unit
`timescale 1ns / 1ps

package ric_pkg;

    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_LINEAR    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_QUADRATIC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPLINE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HERMITE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PCHIP     = 3'd4;

    localparam int NUM_COEFF = 5;

endpackage

/* design/ring_interpolation_coefficients_unit.sv */
// ring interpolation coefficients unit: pipelined slope and curvature coefficients
//
//   channel | signals                                   | direction
//   input   | in_valid, in_stall, value_0..7, center_index | in (stall out)
//   output  | out_valid, out_stall, coeff_0..4           | out (stall in)
//   config  | cfg_we, cfg_wdata                         | in
//
// one transfer per cycle enters while in_stall is low; it passes stages 1 and 2, the divider and the output register
// the pipeline depth is set by the restoring divider of the pchip harmonic mean, one bit per stage
// the whole pipeline advances together; it holds only when the output stage is full
// and stalled, so a stall loses and repeats nothing
// reset clears the valid bits and sets the mode to pchip
`timescale 1ns / 1ps
`include "ring_interpolation_coefficients_unit_defines.svh"

module ring_interpolation_coefficients_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ric_pkg::MODE_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] value_0,
    input  logic signed [VALUE_WIDTH-1:0] value_1,
    input  logic signed [VALUE_WIDTH-1:0] value_2,
    input  logic signed [VALUE_WIDTH-1:0] value_3,
    input  logic signed [VALUE_WIDTH-1:0] value_4,
    input  logic signed [VALUE_WIDTH-1:0] value_5,
    input  logic signed [VALUE_WIDTH-1:0] value_6,
    input  logic signed [VALUE_WIDTH-1:0] value_7,
    input  logic [2:0]                    center_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] coeff_0,
    output logic signed [VALUE_WIDTH-1:0] coeff_1,
    output logic signed [VALUE_WIDTH-1:0] coeff_2,
    output logic signed [VALUE_WIDTH-1:0] coeff_3,
    output logic signed [VALUE_WIDTH-1:0] coeff_4
);

    localparam int W   = VALUE_WIDTH;
    localparam int DW  = W + 1;        // ring difference
    localparam int XW  = W + 6;        // headroom for all mode formulas
    localparam int AW  = W + 1;        // difference magnitude
    localparam int NW  = 2 * AW + 1;   // harmonic mean numerator 2ab
    localparam int QW  = W + 2;        // harmonic mean quotient
    localparam int NST = QW + 4;       // valid bits: s1, s2, divider 0..QW, output

    // mode register
    logic [ric_pkg::MODE_W-1:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= ric_pkg::MODE_PCHIP;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    // valid chain and global advance
    logic [NST-1:0] vld_reg;
    logic           adv;

    assign adv       = !(vld_reg[NST-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // helpers
    function automatic logic signed [XW-1:0] half_tz(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        begin
            t = v + {{(XW-1){1'b0}}, v[XW-1]};
            return t >>> 1;
        end
    endfunction

    function automatic logic signed [XW-1:0] ext_w(input logic signed [W-1:0] v);
        return {{(XW-W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [XW-1:0] ext_d(input logic signed [DW-1:0] v);
        return {{(XW-DW){v[DW-1]}}, v};
    endfunction

    function automatic logic signed [XW-1:0] abs_x(input logic signed [XW-1:0] v);
        return v[XW-1] ? -v : v;
    endfunction

    function automatic logic same_sign(input logic signed [XW-1:0] a,
                                       input logic signed [XW-1:0] b);
        return (a != '0) && (b != '0) && (a[XW-1] == b[XW-1]);
    endfunction

    // pchip end slope with limiting
    function automatic logic signed [XW-1:0] end_slope(input logic signed [XW-1:0] d0,
                                                       input logic signed [XW-1:0] d1);
        logic signed [XW-1:0] t;
        logic signed [XW-1:0] m;
        begin
            t = (d0 <<< 1) + d0;
            m = half_tz(t - d1);
            if (!same_sign(m, d0))
                return '0;
            else if (!same_sign(d0, d1) && (abs_x(m) > abs_x(t)))
                return t;
            else
                return m;
        end
    endfunction

    function automatic logic signed [W-1:0] pick8(input logic [2:0] idx,
        input logic signed [W-1:0] v0, input logic signed [W-1:0] v1,
        input logic signed [W-1:0] v2, input logic signed [W-1:0] v3,
        input logic signed [W-1:0] v4, input logic signed [W-1:0] v5,
        input logic signed [W-1:0] v6, input logic signed [W-1:0] v7);
        logic signed [W-1:0] r;
        begin
            case (idx)
                3'd0:    r = v0;
                3'd1:    r = v1;
                3'd2:    r = v2;
                3'd3:    r = v3;
                3'd4:    r = v4;
                3'd5:    r = v5;
                3'd6:    r = v6;
                default: r = v7;
            endcase
            return r;
        end
    endfunction

    // stage 1: pick center and neighbors
    logic signed [W-1:0] c_reg, r1_reg, r2_reg, l1_reg, l2_reg;
    logic                odd1_reg;
    logic [ric_pkg::MODE_W-1:0] mode1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg  <= pick8(center_index, value_0, value_1, value_2, value_3,
                            value_4, value_5, value_6, value_7);
            r1_reg <= pick8(center_index + 3'd1, value_0, value_1, value_2, value_3,
                            value_4, value_5, value_6, value_7);
            r2_reg <= pick8(center_index + 3'd2, value_0, value_1, value_2, value_3,
                            value_4, value_5, value_6, value_7);
            l1_reg <= pick8(center_index + 3'd7, value_0, value_1, value_2, value_3,
                            value_4, value_5, value_6, value_7);
            l2_reg <= pick8(center_index + 3'd6, value_0, value_1, value_2, value_3,
                            value_4, value_5, value_6, value_7);
            odd1_reg  <= center_index[0];
            mode1_reg <= mode_reg;
        end
    end

    // stage 2: closed-form modes and pchip differences
    logic signed [XW-1:0] c_x, r1_x, r2_x, l1_x, l2_x;
    logic signed [XW-1:0] m_next [0:ric_pkg::NUM_COEFF-1];
    logic signed [XW-1:0] qa, qb, sa;
    logic signed [DW-1:0] e0a_next, e1a_next, e0b_next, e1b_next;
    logic                 pchip_next;

    assign c_x  = ext_w(c_reg);
    assign r1_x = ext_w(r1_reg);
    assign r2_x = ext_w(r2_reg);
    assign l1_x = ext_w(l1_reg);
    assign l2_x = ext_w(l2_reg);

    always_comb
    begin
        for (int k = 0; k < ric_pkg::NUM_COEFF; k++)
            m_next[k] = '0;
        pchip_next = 1'b0;
        qa = '0;
        qb = '0;
        sa = '0;
        case (mode1_reg)
            ric_pkg::MODE_LINEAR:
            begin
            end
            ric_pkg::MODE_QUADRATIC:
            begin
                m_next[0] = c_x;
                if (!odd1_reg)
                begin
                    qa = half_tz(r2_x + c_x - (r1_x <<< 1));
                    qb = half_tz(l2_x + c_x - (l1_x <<< 1));
                    m_next[2] = qa;
                    m_next[1] = r1_x - c_x - qa;
                    m_next[4] = qb;
                    m_next[3] = l1_x - c_x - qb;
                end
                else
                begin
                    qa = half_tz(r1_x + l1_x - (c_x <<< 1));
                    m_next[2] = qa;
                    m_next[4] = qa;
                    m_next[1] = c_x - l1_x + qa;
                    m_next[3] = c_x - r1_x + qa;
                end
            end
            ric_pkg::MODE_SPLINE:
            begin
                if (!odd1_reg)
                begin
                    qa = c_x - (r1_x <<< 1) + r2_x;
                    qb = c_x - (l1_x <<< 1) + l2_x;
                    m_next[1] = half_tz((qa <<< 1) + qa);
                    m_next[3] = half_tz((qb <<< 1) + qb);
                end
                else
                begin
                    qa = l1_x - (c_x <<< 1) + r1_x;
                    m_next[0] = half_tz((qa <<< 1) + qa);
                    m_next[2] = m_next[0];
                end
            end
            ric_pkg::MODE_HERMITE:
            begin
                if (!odd1_reg)
                begin
                    m_next[0] = r1_x - c_x;
                    m_next[1] = half_tz(r2_x - c_x);
                    m_next[2] = l1_x - c_x;
                    m_next[3] = half_tz(l2_x - c_x);
                end
                else
                begin
                    sa = half_tz(r1_x - l1_x);
                    m_next[0] = sa;
                    m_next[1] = r1_x - c_x;
                    m_next[2] = -sa;
                    m_next[3] = l1_x - c_x;
                end
            end
            default:
                pchip_next = 1'b1;
        endcase
    end

    // end-slope argument order: odd centers swap the pair; harmonic mean is symmetric
    always_comb
    begin
        if (!odd1_reg)
        begin
            e0a_next = DW'(r1_x - c_x);
            e1a_next = DW'(r2_x - r1_x);
            e0b_next = DW'(l1_x - c_x);
            e1b_next = DW'(l2_x - l1_x);
        end
        else
        begin
            e0a_next = DW'(r1_x - c_x);
            e1a_next = DW'(c_x - l1_x);
            e0b_next = DW'(l1_x - c_x);
            e1b_next = DW'(c_x - r1_x);
        end
    end

    logic signed [XW-1:0] m2_reg [0:ric_pkg::NUM_COEFF-1];
    logic signed [DW-1:0] e0_reg [0:1];
    logic signed [DW-1:0] e1_reg [0:1];
    logic                 odd2_reg, pchip2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < ric_pkg::NUM_COEFF; k++)
                m2_reg[k] <= m_next[k];
            e0_reg[0]  <= e0a_next;
            e1_reg[0]  <= e1a_next;
            e0_reg[1]  <= e0b_next;
            e1_reg[1]  <= e1b_next;
            odd2_reg   <= odd1_reg;
            pchip2_reg <= pchip_next;
        end
    end

    // stage 3: end slopes, harmonic mean numerator and divisor
    // divider arrays: index 0 is loaded here, index QW holds the finished quotient
    logic [NW-1:0]        rem_reg [0:QW][0:1];
    logic [QW-1:0]        quo_reg [0:QW][0:1];
    logic [AW:0]          div_reg [0:QW][0:1];
    logic                 neg_reg [0:QW][0:1];
    logic                 ok_reg  [0:QW][0:1];
    logic signed [XW-1:0] es_reg  [0:QW][0:1];
    logic signed [XW-1:0] md_reg  [0:QW][0:ric_pkg::NUM_COEFF-1];
    logic                 odd_d_reg   [0:QW];
    logic                 pchip_d_reg [0:QW];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 2; l++)
            begin
                logic [AW-1:0] a_mag;
                logic [AW-1:0] b_mag;
                a_mag = AW'(e0_reg[l][DW-1] ? -ext_d(e0_reg[l]) : ext_d(e0_reg[l]));
                b_mag = AW'(e1_reg[l][DW-1] ? -ext_d(e1_reg[l]) : ext_d(e1_reg[l]));
                rem_reg[0][l] <= {(2*AW)'(a_mag) * (2*AW)'(b_mag), 1'b0};
                quo_reg[0][l] <= '0;
                div_reg[0][l] <= {1'b0, a_mag} + {1'b0, b_mag};
                neg_reg[0][l] <= e0_reg[l][DW-1];
                ok_reg[0][l]  <= same_sign(ext_d(e0_reg[l]), ext_d(e1_reg[l]));
                es_reg[0][l]  <= end_slope(ext_d(e0_reg[l]), ext_d(e1_reg[l]));
            end
            for (int k = 0; k < ric_pkg::NUM_COEFF; k++)
                md_reg[0][k] <= m2_reg[k];
            odd_d_reg[0]   <= odd2_reg;
            pchip_d_reg[0] <= pchip2_reg;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar i = 0; i < QW; i++)
    begin : g_div
        localparam int BIT = QW - 1 - i;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    logic [NW-1:0] trial;
                    trial = {{(NW-AW-1){1'b0}}, div_reg[i][l]} << BIT;
                    if (rem_reg[i][l] >= trial)
                    begin
                        rem_reg[i+1][l]      <= rem_reg[i][l] - trial;
                        quo_reg[i+1][l]      <= quo_reg[i][l] | (QW'(1) << BIT);
                    end
                    else
                    begin
                        rem_reg[i+1][l]      <= rem_reg[i][l];
                        quo_reg[i+1][l]      <= quo_reg[i][l];
                    end
                    div_reg[i+1][l] <= div_reg[i][l];
                    neg_reg[i+1][l] <= neg_reg[i][l];
                    ok_reg[i+1][l]  <= ok_reg[i][l];
                    es_reg[i+1][l]  <= es_reg[i][l];
                end
                for (int k = 0; k < ric_pkg::NUM_COEFF; k++)
                    md_reg[i+1][k] <= md_reg[i][k];
                odd_d_reg[i+1]   <= odd_d_reg[i];
                pchip_d_reg[i+1] <= pchip_d_reg[i];
            end
        end
    end

    // output stage: place pchip results, saturate to the value width
    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
        if (v[XW-1] && !(&v[XW-2:W-1]))
            return {1'b1, {(W-1){1'b0}}};
        else if (!v[XW-1] && (|v[XW-2:W-1]))
            return {1'b0, {(W-1){1'b1}}};
        else
            return v[W-1:0];
    endfunction

    logic signed [XW-1:0] hm   [0:1];
    logic signed [XW-1:0] fin  [0:ric_pkg::NUM_COEFF-1];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic signed [XW-1:0] qx;
            qx = {{(XW-QW){1'b0}}, quo_reg[QW][l]};
            if (!ok_reg[QW][l])
                hm[l] = '0;
            else
                hm[l] = neg_reg[QW][l] ? -qx : qx;
        end
        for (int k = 0; k < ric_pkg::NUM_COEFF; k++)
            fin[k] = md_reg[QW][k];
        if (pchip_d_reg[QW])
        begin
            if (!odd_d_reg[QW])
            begin
                fin[0] = es_reg[QW][0];
                fin[1] = hm[0];
                fin[2] = es_reg[QW][1];
                fin[3] = hm[1];
            end
            else
            begin
                fin[0] = hm[0];
                fin[1] = es_reg[QW][0];
                fin[2] = hm[1];
                fin[3] = es_reg[QW][1];
            end
            fin[4] = '0;
        end
    end

    logic signed [W-1:0] coeff_reg [0:ric_pkg::NUM_COEFF-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < ric_pkg::NUM_COEFF; k++)
                coeff_reg[k] <= sat_w(fin[k]);
        end
    end

    assign coeff_0 = coeff_reg[0];
    assign coeff_1 = coeff_reg[1];
    assign coeff_2 = coeff_reg[2];
    assign coeff_3 = coeff_reg[3];
    assign coeff_4 = coeff_reg[4];

    // checks
    `RIC_ASSERT_SAME(a_stall_only_when_full, in_stall, out_valid && out_stall)
    `RIC_ASSERT_NEXT(a_pipe_frozen, out_valid && out_stall, $stable(vld_reg))
    `RIC_ASSERT_NEXT(a_entry_tracked, in_valid && !in_stall, vld_reg[0])

endmodule
